// ===== hw/rtl/yuvrgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package yuvrgb_pkg;

    // Sample and register widths
    localparam int PIX_W    = 8;
    localparam int CHROMA_W = 2 * PIX_W;
    localparam int CFG_W    = 12;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(LINE_DEPTH);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // Fixed-point colour matrix, coefficients rounded half up
    localparam int COEF_FRAC_BITS = 10;
    localparam int COEF_W         = COEF_FRAC_BITS + 3;
    localparam int DIFF_W         = PIX_W + 1;
    localparam int PROD_W         = COEF_W + DIFF_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int LUMA_SC_W      = PIX_W + COEF_FRAC_BITS;

    localparam logic signed [COEF_W-1:0] COEF_RV =
        COEF_W'((1140 * (1 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [COEF_W-1:0] COEF_GU =
        COEF_W'((396 * (1 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [COEF_W-1:0] COEF_GV =
        COEF_W'((581 * (1 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [COEF_W-1:0] COEF_BU =
        COEF_W'((2029 * (1 << COEF_FRAC_BITS) + 500) / 1000);

    localparam logic [PIX_W-1:0] CHROMA_OFFSET = PIX_W'(128);
    localparam logic [PIX_W-1:0] CHAN_MAX      = PIX_W'(255);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== hw/rtl/yuvrgb_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface yuvrgb_pix_if;
    import yuvrgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;

    modport source (output valid, output luma, output chroma_blue, output chroma_red,
                    input ready);
    modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/yuvrgb_rgb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface yuvrgb_rgb_if;
    import yuvrgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/yuv420_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Request carries
// i_pix       in         luma, chroma_blue, chroma_red (chroma used at even row/col)
// o_rgb       out        red, green, blue, frame_end
// i_cfg_*     in         register write: index, 12-bit data, no read-back
//
// One request per clock sustained while o_rgb is not stalled; three register
// stages (line store read, coefficient multiply, sum/clamp), and o_rgb is
// driven straight from the sum/clamp register.
// Reset (synchronous, active low) clears counters, held chroma and the pipeline;
// the chroma line store is not cleared and needs no clearing pass.
// A stall on o_rgb back-pressures stage by stage; i_pix.ready drops only once
// every stage holds a request and o_rgb is stalled.

module yuv420_to_rgb_converter_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    yuvrgb_pix_if.sink            i_pix,
    yuvrgb_rgb_if.source          o_rgb,
    input  wire                   i_cfg_we,
    input  yuvrgb_pkg::t_cfg_idx  i_cfg_idx,
    input  wire [yuvrgb_pkg::CFG_W-1:0] i_cfg_data
);
    import yuvrgb_pkg::*;

    // Configuration
    logic [CFG_W-1:0] r_width_cfg;
    logic [CFG_W-1:0] r_height_cfg;

    // Raster position and held chroma pair (U high byte, V low byte)
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CHROMA_W-1:0] r_cur_chroma;

    // Chroma line store, one pair per 2-pixel column
    logic [CHROMA_W-1:0] r_line [LINE_DEPTH];
    logic [CHROMA_W-1:0] r_mem_rd;

    // Stage 1: line store read in flight
    logic                r_s1_valid;
    logic                r_s1_use_mem;
    logic [CHROMA_W-1:0] r_s1_chroma;
    logic [PIX_W-1:0]    r_s1_luma;
    logic                r_s1_end;

    // Stage 2: products registered
    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_s2_prv, r_s2_pgu, r_s2_pgv, r_s2_pbu;
    logic [PIX_W-1:0]         r_s2_luma;
    logic                     r_s2_end;

    // Stage 3: output register
    logic             r_s3_valid;
    logic [PIX_W-1:0] r_s3_red, r_s3_green, r_s3_blue;
    logic             r_s3_end;

    // Handshake and flow control
    logic s3_free, s2_free, s1_free, s1_move, s2_move, in_acc;

    // Geometry
    logic [CFG_W-1:0] width_used, height_used, width_last, height_last;
    logic             last_col, last_row, even_col, even_row;
    logic [SLOT_W-1:0] slot;
    logic [CHROMA_W-1:0] in_chroma, fwd_chroma;

    // Arithmetic
    logic [CHROMA_W-1:0]      s1_chroma;
    logic signed [DIFF_W-1:0] du, dv;
    logic signed [SUM_W-1:0]  ys, sum_r, sum_g, sum_b;

    function automatic logic [PIX_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        logic [PIX_W-1:0]        res;
        q = s >>> COEF_FRAC_BITS;
        if (s < 0) begin
            res = '0;
        end else if (q > $signed(SUM_W'(CHAN_MAX))) begin
            res = CHAN_MAX;
        end else begin
            res = q[PIX_W-1:0];
        end
        return res;
    endfunction

    // Advance a stage when the next one is empty or moving on
    assign s3_free = !r_s3_valid || o_rgb.ready;
    assign s2_move = r_s2_valid && s3_free;
    assign s2_free = !r_s2_valid || s3_free;
    assign s1_move = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s2_free;
    assign in_acc  = i_pix.valid && s1_free;
    assign i_pix.ready = s1_free;

    // Clamp width to 2..MAX_WIDTH and round down to even; height to 1..MAX_HEIGHT
    always_comb begin
        if (r_width_cfg < CFG_W'(2)) begin
            width_used = CFG_W'(2);
        end else if (r_width_cfg > CFG_W'(MAX_WIDTH)) begin
            width_used = CFG_W'(MAX_WIDTH);
        end else begin
            width_used = {r_width_cfg[CFG_W-1:1], 1'b0};
        end
        if (r_height_cfg < CFG_W'(1)) begin
            height_used = CFG_W'(1);
        end else if (r_height_cfg > CFG_W'(MAX_HEIGHT)) begin
            height_used = CFG_W'(MAX_HEIGHT);
        end else begin
            height_used = r_height_cfg;
        end
    end

    assign width_last  = width_used - CFG_W'(1);
    assign height_last = height_used - CFG_W'(1);
    assign last_col    = CFG_W'(r_col) >= width_last;
    assign last_row    = CFG_W'(r_row) >= height_last;
    assign even_col    = !r_col[0];
    assign even_row    = !r_row[0];
    assign slot        = r_col[SLOT_W:1];
    assign in_chroma   = {i_pix.chroma_blue, i_pix.chroma_red};

    // The previous request may still be waiting on its line store read
    assign fwd_chroma = (r_s1_valid && r_s1_use_mem) ? r_mem_rd : r_cur_chroma;

    // Wrap the column at row end, the row at frame end
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= WIDTH_RESET;
            r_height_cfg <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_width_cfg  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Even row writes the pair, odd row reads it back at the same slot.
    // A slot is written and read by different requests at least a row apart,
    // so no forwarding around the store is needed.
    always_ff @(posedge i_clk) begin
        if (in_acc && even_col && even_row) begin
            r_line[slot] <= in_chroma;
        end
        if (in_acc && even_col && !even_row) begin
            r_mem_rd <= r_line[slot];
        end
    end

    // Held pair: a fresh pair on acceptance wins over a returning store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_chroma <= '0;
        end else if (in_acc && even_col && even_row) begin
            r_cur_chroma <= in_chroma;
        end else if (s1_move && r_s1_use_mem) begin
            r_cur_chroma <= r_mem_rd;
        end
    end

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_use_mem <= even_col && !even_row;
            r_s1_chroma  <= (even_col && even_row) ? in_chroma : fwd_chroma;
            r_s1_luma    <= i_pix.luma;
            r_s1_end     <= last_col && last_row;
        end
    end

    // Stage 2: chroma offsets and products
    assign s1_chroma = r_s1_use_mem ? r_mem_rd : r_s1_chroma;
    assign du = $signed(DIFF_W'(s1_chroma[CHROMA_W-1:PIX_W]) - DIFF_W'(CHROMA_OFFSET));
    assign dv = $signed(DIFF_W'(s1_chroma[PIX_W-1:0]) - DIFF_W'(CHROMA_OFFSET));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_prv  <= PROD_W'(COEF_RV) * PROD_W'(dv);
            r_s2_pgu  <= PROD_W'(COEF_GU) * PROD_W'(du);
            r_s2_pgv  <= PROD_W'(COEF_GV) * PROD_W'(dv);
            r_s2_pbu  <= PROD_W'(COEF_BU) * PROD_W'(du);
            r_s2_luma <= r_s1_luma;
            r_s2_end  <= r_s1_end;
        end
    end

    // Stage 3: sum, truncate toward zero, clamp
    assign ys    = $signed(SUM_W'({r_s2_luma, {COEF_FRAC_BITS{1'b0}}}));
    assign sum_r = ys + SUM_W'(r_s2_prv);
    assign sum_g = ys - SUM_W'(r_s2_pgu) - SUM_W'(r_s2_pgv);
    assign sum_b = ys + SUM_W'(r_s2_pbu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_s3_red   <= clamp_chan(sum_r);
            r_s3_green <= clamp_chan(sum_g);
            r_s3_blue  <= clamp_chan(sum_b);
            r_s3_end   <= r_s2_end;
        end
    end

    assign o_rgb.valid     = r_s3_valid;
    assign o_rgb.red       = r_s3_red;
    assign o_rgb.green     = r_s3_green;
    assign o_rgb.blue      = r_s3_blue;
    assign o_rgb.frame_end = r_s3_end;

endmodule

`default_nettype wire

// ===== hw/rtl/yuvrgb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module yuvrgb_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [yuvrgb_pkg::PIX_W-1:0]  i_red,
    input wire [yuvrgb_pkg::PIX_W-1:0]  i_green,
    input wire [yuvrgb_pkg::PIX_W-1:0]  i_blue,
    input wire                          i_frame_end
);
    import yuvrgb_pkg::*;

    // Requests accepted but not yet delivered
    logic [2:0] r_inflight;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_acc) - 3'(out_acc);
        end
    end

    // Hold the result while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue)
             && $stable(i_frame_end)))
        else $error("result changed while stalled");

    // The pipeline holds at most three requests
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd3)
        else $error("more requests in flight than pipeline stages");

    // No result without a request behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 3'd0) |-> !i_out_valid)
        else $error("result presented with nothing in flight");

    // A full pipeline takes a request only as one leaves
    a_full_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 3'd3) |-> (i_in_ready == i_out_ready))
        else $error("input ready wrong with all stages full");

endmodule

bind yuv420_to_rgb_converter_top yuvrgb_checker u_yuvrgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue),
    .i_frame_end (o_rgb.frame_end)
);

`default_nettype wire
